// File: rtl/pack_index_entry_parser_macros.svh
`ifndef PACK_INDEX_ENTRY_PARSER_MACROS_SVH
`define PACK_INDEX_ENTRY_PARSER_MACROS_SVH

// concurrent check that a condition holds at every clock edge outside reset
`define PIEP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("piep check failed");

// concurrent check of an implication property outside reset
`define PIEP_ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("piep property failed");

`endif

// File: rtl/piep_pkg.sv
package piep_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [23:0] MAX_ENTRIES_RESET = 24'd1000000;

  // record_status codes
  localparam logic [1:0] REC_ENTRY   = 2'd0;
  localparam logic [1:0] REC_SUCCESS = 2'd1;
  localparam logic [1:0] REC_INVALID = 2'd2;
  localparam logic [1:0] REC_CORRUPT = 2'd3;

  // parse outcome codes
  localparam logic [1:0] OUTCOME_BUSY    = 2'd0;
  localparam logic [1:0] OUTCOME_SUCCESS = 2'd1;
  localparam logic [1:0] OUTCOME_CORRUPT = 2'd3;

  typedef enum logic [10:0] {
    STEP_COUNT = 11'b000_0000_0001,
    STEP_PACK  = 11'b000_0000_0010,
    STEP_POS   = 11'b000_0000_0100,
    STEP_SSIZE = 11'b000_0000_1000,
    STEP_SCRC  = 11'b000_0001_0000,
    STEP_CTYPE = 11'b000_0010_0000,
    STEP_CODE  = 11'b000_0100_0000,
    STEP_OSIZE = 11'b000_1000_0000,
    STEP_OCRC  = 11'b001_0000_0000,
    STEP_NAME  = 11'b010_0000_0000,
    STEP_IDLE  = 11'b100_0000_0000
  } piep_step_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } piep_in_t;

  typedef struct packed {
    logic [1:0]  record_status;
    logic [31:0] pack_index;
    logic [31:0] position;
    logic [31:0] stored_size;
    logic [31:0] stored_crc;
    logic [31:0] compress_type;
    logic [31:0] code_type;
    logic [31:0] original_size;
    logic [31:0] original_crc;
    logic [31:0] name_crc;
    logic [51:0] total_bytes;
    logic        last;
  } piep_out_t;

endpackage

// File: rtl/pack_index_entry_parser.sv
// Pack index parser: takes the index buffer one byte per beat (final_byte on
// the last), builds little-endian words, reads the entry count and then the
// variable-length entries, and emits one record per finished entry followed
// by a status record (last = 1) on the final byte. An error status (invalid
// format or corrupted) tells downstream to drop the entry records already
// seen. One byte is taken per cycle while byte_ready is high; all parsing sits
// between the field state registers and a four-deep result queue. A byte that
// both ends an entry and ends the buffer pushes two records, and byte_ready is
// low while the queue holds more than two records, so the sustained rate is
// one byte per cycle whenever record_ready stays high. No clearing pass after
// reset. The user must write max_entries through cfg_we/cfg_wdata only while idle; the block does not enforce it.
`include "pack_index_entry_parser_macros.svh"

module pack_index_entry_parser
  import piep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  piep_in_t    byte_data,
  output logic        record_valid,
  input  logic        record_ready,
  output piep_out_t   record
);

  logic [23:0]  max_entries;
  logic [23:0]  word_shift, word_shift_next;
  logic [1:0]   byte_in_word, byte_in_word_next;
  piep_step_t   field_step, field_step_next;
  logic [23:0]  entries_left, entries_left_next;
  logic [31:0]  entry_fields [8];
  logic [31:0]  entry_fields_next [8];
  logic [51:0]  running_total, running_total_next;
  logic [1:0]   parse_outcome, parse_outcome_next;

  logic         accept;
  logic [31:0]  word;
  logic [52:0]  total_sum;
  logic         ent_push, stat_push;
  piep_out_t    ent_rec, stat_rec;

  piep_out_t             queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr, stat_addr;
  logic [QUEUE_CW-1:0]   q_count;
  logic [1:0]            push_n;
  logic                  pop;

  assign accept    = byte_valid & byte_ready;
  assign word      = {byte_data.data_byte, word_shift};
  assign total_sum = {1'b0, running_total} + {21'b0, entry_fields[6]};

  always_comb begin
    word_shift_next    = word_shift;
    byte_in_word_next  = byte_in_word;
    field_step_next    = field_step;
    entries_left_next  = entries_left;
    entry_fields_next  = entry_fields;
    running_total_next = running_total;
    parse_outcome_next = parse_outcome;
    ent_push           = 1'b0;
    stat_push          = 1'b0;
    ent_rec            = '0;
    stat_rec           = '0;

    if (accept) begin
      if (field_step != STEP_IDLE) begin
        if (byte_in_word == 2'd3) begin
          byte_in_word_next = 2'd0;
          unique case (field_step)
            STEP_COUNT: begin
              if (word > {8'b0, max_entries}) begin
                parse_outcome_next = OUTCOME_CORRUPT;
                field_step_next    = STEP_IDLE;
              end else if (word == 32'd0) begin
                parse_outcome_next = OUTCOME_SUCCESS;
                field_step_next    = STEP_IDLE;
              end else begin
                entries_left_next = word[23:0];
                field_step_next   = STEP_PACK;
              end
            end
            STEP_PACK: begin
              entry_fields_next[0] = word;
              if (word != 32'd0) begin
                field_step_next = STEP_POS;
              end else begin
                entry_fields_next[1] = 32'd0;
                field_step_next      = STEP_SSIZE;
              end
            end
            STEP_POS: begin
              entry_fields_next[1] = word;
              field_step_next      = STEP_SSIZE;
            end
            STEP_SSIZE: begin
              entry_fields_next[2] = word;
              field_step_next      = STEP_SCRC;
            end
            STEP_SCRC: begin
              entry_fields_next[3] = word;
              field_step_next      = STEP_CTYPE;
            end
            STEP_CTYPE: begin
              entry_fields_next[4] = word;
              field_step_next      = STEP_CODE;
            end
            STEP_CODE: begin
              entry_fields_next[5] = word;
              if ((entry_fields[4] | word) != 32'd0) begin
                field_step_next = STEP_OSIZE;
              end else begin
                entry_fields_next[6] = entry_fields[2];
                entry_fields_next[7] = entry_fields[3];
                field_step_next      = STEP_NAME;
              end
            end
            STEP_OSIZE: begin
              entry_fields_next[6] = word;
              field_step_next      = STEP_OCRC;
            end
            STEP_OCRC: begin
              entry_fields_next[7] = word;
              field_step_next      = STEP_NAME;
            end
            STEP_NAME: begin
              running_total_next     = total_sum[52] ? '1 : total_sum[51:0];
              ent_push               = 1'b1;
              ent_rec.record_status  = REC_ENTRY;
              ent_rec.pack_index     = entry_fields[0];
              ent_rec.position       = entry_fields[1];
              ent_rec.stored_size    = entry_fields[2];
              ent_rec.stored_crc     = entry_fields[3];
              ent_rec.compress_type  = entry_fields[4];
              ent_rec.code_type      = entry_fields[5];
              ent_rec.original_size  = entry_fields[6];
              ent_rec.original_crc   = entry_fields[7];
              ent_rec.name_crc       = word;
              ent_rec.total_bytes    = running_total_next;
              ent_rec.last           = 1'b0;
              entries_left_next      = entries_left - 24'd1;
              if (entries_left == 24'd1) begin
                parse_outcome_next = OUTCOME_SUCCESS;
                field_step_next    = STEP_IDLE;
              end else begin
                field_step_next = STEP_PACK;
              end
            end
            STEP_IDLE: field_step_next = STEP_IDLE;
            default:   field_step_next = STEP_IDLE;
          endcase
        end else begin
          case (byte_in_word)
            2'd0:    word_shift_next[7:0]   = byte_data.data_byte;
            2'd1:    word_shift_next[15:8]  = byte_data.data_byte;
            default: word_shift_next[23:16] = byte_data.data_byte;
          endcase
          byte_in_word_next = byte_in_word + 2'd1;
        end
      end

      if (byte_data.final_byte) begin
        stat_push     = 1'b1;
        stat_rec.last = 1'b1;
        if (parse_outcome_next == OUTCOME_SUCCESS) begin
          stat_rec.record_status = REC_SUCCESS;
          stat_rec.total_bytes   = running_total_next;
        end else if (parse_outcome_next == OUTCOME_CORRUPT) begin
          stat_rec.record_status = REC_CORRUPT;
        end else if (field_step_next == STEP_COUNT) begin
          stat_rec.record_status = REC_INVALID;
        end else begin
          stat_rec.record_status = REC_CORRUPT;
        end
        // next beat starts a new buffer
        word_shift_next    = '0;
        byte_in_word_next  = 2'd0;
        field_step_next    = STEP_COUNT;
        entries_left_next  = '0;
        running_total_next = '0;
        parse_outcome_next = OUTCOME_BUSY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries   <= MAX_ENTRIES_RESET;
      word_shift    <= '0;
      byte_in_word  <= 2'd0;
      field_step    <= STEP_COUNT;
      entries_left  <= '0;
      running_total <= '0;
      parse_outcome <= OUTCOME_BUSY;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      word_shift    <= word_shift_next;
      byte_in_word  <= byte_in_word_next;
      field_step    <= field_step_next;
      entries_left  <= entries_left_next;
      running_total <= running_total_next;
      parse_outcome <= parse_outcome_next;
    end
  end

  always_ff @(posedge clk) begin
    entry_fields <= entry_fields_next;
  end

  // result queue
  assign push_n       = {1'b0, ent_push} + {1'b0, stat_push};
  assign pop          = record_valid & record_ready;
  assign record_valid = (q_count != '0);
  assign record       = queue[rd_ptr];
  assign byte_ready   = (q_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign stat_addr    = ent_push ? (wr_ptr + QUEUE_AW'(1)) : wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QUEUE_AW'(push_n);
      rd_ptr  <= rd_ptr + QUEUE_AW'(pop);
      q_count <= q_count + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ent_push) begin
      queue[wr_ptr] <= ent_rec;
    end
    if (stat_push) begin
      queue[stat_addr] <= stat_rec;
    end
  end

  `PIEP_ASSERT_ALWAYS(a_queue_bound, clk, rst, q_count <= QUEUE_CW'(QUEUE_DEPTH))
  `PIEP_ASSERT_PROP(a_queue_hold, clk, rst, (!accept && !pop) |=> $stable(q_count))
  `PIEP_ASSERT_PROP(a_final_clears, clk, rst, (accept && byte_data.final_byte) |=> (field_step == STEP_COUNT && byte_in_word == 2'd0 && running_total == '0))
  `PIEP_ASSERT_PROP(a_idle_outcome, clk, rst, (field_step == STEP_IDLE) |-> (parse_outcome != OUTCOME_BUSY))
  `PIEP_ASSERT_PROP(a_last_is_status, clk, rst, (record_valid && record.last) |-> (record.record_status != REC_ENTRY))

endmodule

// File: tb/sv/index_record_checker.sv
module index_record_checker
  import piep_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic      byte_valid,
  input  logic      byte_ready,
  input  piep_in_t  byte_data,
  input  logic      record_valid,
  input  logic      record_ready,
  input  piep_out_t record,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  piep_out_t   expected_records[$];

  logic [23:0] entry_limit;
  logic [31:0] word_acc;
  logic [1:0]  byte_pos;
  piep_step_t  step;
  logic [23:0] entries_left;
  logic [31:0] fld[8];
  logic [51:0] size_total;
  logic [1:0]  outcome;

  task automatic clear_parse();
    word_acc = '0;
    byte_pos = '0;
    step = STEP_COUNT;
    entries_left = '0;
    for (int i = 0; i < 8; i++) fld[i] = '0;
    size_total = '0;
    outcome = OUTCOME_BUSY;
  endtask

  task automatic expect_record(input piep_out_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  // one byte of the index buffer through the field state machine
  task automatic parse_byte(input piep_in_t b);
    piep_out_t   rec;
    logic [31:0] w;
    logic [52:0] sum;
    logic [1:0]  st;
    if (step != STEP_IDLE) begin
      if (byte_pos == 2'd3) begin
        w = word_acc | {b.data_byte, 24'd0};
        word_acc = '0;
        byte_pos = '0;
        case (step)
          STEP_COUNT: begin
            if (w > {8'd0, entry_limit}) begin
              outcome = OUTCOME_CORRUPT;
              step = STEP_IDLE;
            end else if (w == 32'd0) begin
              outcome = OUTCOME_SUCCESS;
              step = STEP_IDLE;
            end else begin
              entries_left = w[23:0];
              step = STEP_PACK;
            end
          end
          STEP_PACK: begin
            fld[0] = w;
            if (w != 32'd0) begin
              step = STEP_POS;
            end else begin
              fld[1] = '0;
              step = STEP_SSIZE;
            end
          end
          STEP_POS: begin
            fld[1] = w;
            step = STEP_SSIZE;
          end
          STEP_SSIZE: begin
            fld[2] = w;
            step = STEP_SCRC;
          end
          STEP_SCRC: begin
            fld[3] = w;
            step = STEP_CTYPE;
          end
          STEP_CTYPE: begin
            fld[4] = w;
            step = STEP_CODE;
          end
          STEP_CODE: begin
            fld[5] = w;
            if ((fld[4] | fld[5]) != 32'd0) begin
              step = STEP_OSIZE;
            end else begin
              fld[6] = fld[2];
              fld[7] = fld[3];
              step = STEP_NAME;
            end
          end
          STEP_OSIZE: begin
            fld[6] = w;
            step = STEP_OCRC;
          end
          STEP_OCRC: begin
            fld[7] = w;
            step = STEP_NAME;
          end
          STEP_NAME: begin
            sum = {1'b0, size_total} + {21'd0, fld[6]};
            size_total = sum[52] ? '1 : sum[51:0];
            rec = '0;
            rec.record_status = REC_ENTRY;
            rec.pack_index = fld[0];
            rec.position = fld[1];
            rec.stored_size = fld[2];
            rec.stored_crc = fld[3];
            rec.compress_type = fld[4];
            rec.code_type = fld[5];
            rec.original_size = fld[6];
            rec.original_crc = fld[7];
            rec.name_crc = w;
            rec.total_bytes = size_total;
            rec.last = 1'b0;
            expect_record(rec);
            entries_left = entries_left - 24'd1;
            if (entries_left == 24'd0) begin
              outcome = OUTCOME_SUCCESS;
              step = STEP_IDLE;
            end else begin
              step = STEP_PACK;
            end
          end
          default: step = STEP_IDLE;
        endcase
      end else begin
        word_acc = word_acc | ({24'd0, b.data_byte} << (8 * byte_pos));
        byte_pos = byte_pos + 2'd1;
      end
    end
    if (b.final_byte) begin
      if (outcome == OUTCOME_SUCCESS) st = REC_SUCCESS;
      else if (outcome == OUTCOME_CORRUPT) st = REC_CORRUPT;
      else if (step == STEP_COUNT) st = REC_INVALID;
      else st = REC_CORRUPT;
      rec = '0;
      rec.record_status = st;
      rec.total_bytes = (st == REC_SUCCESS) ? size_total : '0;
      rec.last = 1'b1;
      expect_record(rec);
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    piep_out_t want;
    if (rst) begin
      clear_parse();
      entry_limit = MAX_ENTRIES_RESET;
      expected_records.delete();
      errors = 0;
    end else begin
      if (byte_valid && byte_ready) parse_byte(byte_data);
      if (cfg_we) entry_limit = cfg_wdata;
      if (record_valid && record_ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: record beat with nothing expected, got %0h", $time, record);
          errors++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_status", 64'(want.record_status),
                      64'(record.record_status));
          check_field("pack_index", 64'(want.pack_index), 64'(record.pack_index));
          check_field("position", 64'(want.position), 64'(record.position));
          check_field("stored_size", 64'(want.stored_size), 64'(record.stored_size));
          check_field("stored_crc", 64'(want.stored_crc), 64'(record.stored_crc));
          check_field("compress_type", 64'(want.compress_type),
                      64'(record.compress_type));
          check_field("code_type", 64'(want.code_type), 64'(record.code_type));
          check_field("original_size", 64'(want.original_size),
                      64'(record.original_size));
          check_field("original_crc", 64'(want.original_crc),
                      64'(record.original_crc));
          check_field("name_crc", 64'(want.name_crc), 64'(record.name_crc));
          check_field("total_bytes", 64'(want.total_bytes), 64'(record.total_bytes));
          check_field("last", 64'(want.last), 64'(record.last));
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import piep_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_BYTES  = 550;
  localparam int DRAIN_WAIT  = 8;
  localparam int END_WAIT    = 20;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        byte_valid;
  logic        byte_ready;
  piep_in_t    byte_data;
  logic        record_valid;
  logic        record_ready;
  piep_out_t   record;

  int          errors;
  int          pending;

  int          tx_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs;
  int          hold_taken;
  int          hold_left;
  int          idle_cycles;
  int          bytes_sent;
  logic [23:0] max_tb;
  logic [7:0]  bytes_q[$];

  pack_index_entry_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record       (record)
  );

  index_record_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record       (record),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    record_ready = 1'b0;
    hold_left = 0;
    hold_taken = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        record_ready <= 1'b0;
      end else begin
        record_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (record_valid && record_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic append_byte(input logic [7:0] b);
    bytes_q.insert(bytes_q.size(), b);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) append_byte(w[8*i +: 8]);
  endtask

  task automatic add_entry();
    logic [31:0] pack;
    logic [31:0] ctype;
    logic [31:0] code;
    pack = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
    if ($urandom_range(2) == 0) begin
      ctype = '0;
      code = '0;
    end else begin
      ctype = $urandom_range(1) ? $urandom : 32'd0;
      code = $urandom_range(1) ? $urandom : 32'd0;
    end
    push_word(pack);
    if (pack != 32'd0) push_word($urandom);
    push_word($urandom);
    push_word($urandom);
    push_word(ctype);
    push_word(code);
    if ((ctype | code) != 32'd0) begin
      push_word($urandom);
      push_word($urandom);
    end
    push_word($urandom);
  endtask

  task automatic build_good(input int n);
    bytes_q.delete();
    push_word(32'(n));
    for (int i = 0; i < n; i++) add_entry();
  endtask

  task automatic build_random();
    int          pick;
    int          n;
    int          cut;
    logic [31:0] cnt;
    pick = $urandom_range(99);
    n = $urandom_range(1, 3);
    if (int'(max_tb) < n) n = int'(max_tb);
    if (pick < 55) begin
      build_good(n);
    end else if (pick < 70) begin
      build_good(n);
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
    end else if (pick < 85) begin
      build_good(n);
      if (bytes_q.size() > 1) begin
        cut = $urandom_range(1, bytes_q.size() - 1);
        while (bytes_q.size() > cut) void'(bytes_q.pop_back());
      end
    end else if (pick < 92) begin
      bytes_q.delete();
      cnt = {8'd0, max_tb} + 32'd1 + $urandom_range(1000);
      push_word(cnt);
      repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
    end else if (pick < 96) begin
      bytes_q.delete();
      push_word(32'd0);
      repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
    end else begin
      bytes_q.delete();
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    end
  endtask

  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{data_byte: d, final_byte: fin};
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < bytes_q.size(); i++) send_byte(bytes_q[i], i == bytes_q.size() - 1);
    bytes_sent += bytes_q.size();
  endtask

  task automatic write_max(input logic [23:0] v);
    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    max_tb = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int buf_idx;
    int cfg_sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    byte_valid = 1'b0;
    byte_data = '0;
    hold_reqs = 0;
    bytes_sent = 0;
    max_tb = MAX_ENTRIES_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short headers, empty index, trailing bytes, count too big, truncation
    bytes_q = '{8'hFF};
    send_buffer();
    bytes_q = '{8'h01, 8'h02, 8'h03};
    send_buffer();
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer();
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55};
    send_buffer();
    bytes_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E};
    send_buffer();
    bytes_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34};
    send_buffer();

    // long receiver hold-off while a full buffer is offered
    hold_reqs++;
    build_good(3);
    send_buffer();

    buf_idx = 0;
    cfg_sel = 0;
    while (bytes_sent < RAND_BYTES) begin
      if (buf_idx % 5 == 0) begin
        case (cfg_sel % 5)
          0: write_max(24'hFFFFFF);
          1: write_max(24'd0);
          2: write_max(24'($urandom_range(1, 3)));
          3: write_max(24'($urandom_range(24'hFFFFFF)));
          default: write_max(24'd1);
        endcase
        cfg_sel++;
      end
      case (buf_idx % 4)
        0: begin
          tx_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          tx_idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      build_random();
      send_buffer();
      buf_idx++;
    end
    write_max(MAX_ENTRIES_RESET);
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer();

    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
